FILE: hw/rtl/spur_pkg.sv
// spur_pkg: widths, register indexes, reset values and the command/status
// structs shared by the controller and the datapath of the ultrasonic ranger.
// No dependencies.
`default_nettype none

package spur_pkg;

   localparam int TRIG_W     = 16;
   localparam int TOUT_W     = 24;
   localparam int TPM_W      = 20;
   localparam int MM_W       = 10;
   localparam int DIST_W     = 16;
   localparam int TICK_W     = 24;   // phase tick counter, bounded by trigger_ticks or timeout_ticks

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int FLAG_W     = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TICKS_PER_MS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MM_PER_MS     = 2'd3;

   // register reset values
   localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 16'd10;
   localparam logic [TOUT_W-1:0] TIMEOUT_TICKS_RST = 24'd10000;
   localparam logic [TPM_W-1:0]  TICKS_PER_MS_RST  = 20'd1000;
   localparam logic [MM_W-1:0]   MM_PER_MS_RST     = 10'd171;

   typedef struct packed {
      logic cnt_clr;     // clear phase tick counter (wins over cnt_inc)
      logic cnt_inc;     // advance phase tick counter
      logic high_set;    // echo rising: high count starts at one
      logic high_inc;    // echo still high: saturating increment
      logic mul_go;      // register mm_per_ms * high count
      logic div_go;      // start divide of the product by ticks_per_ms
      logic dist_load;   // take the saturated quotient as the new distance
      logic rsp_load;    // load the response flag register
      logic rsp_en;
      logic rsp_lvl;
      logic rsp_busy;
      logic rsp_done;
      logic rsp_tout;
   } cmd_type;

   typedef struct packed {
      logic trig_hit;    // next trigger tick reaches trigger_ticks
      logic tout_hit;    // next released tick reaches timeout_ticks
      logic div_done;    // quotient ready
   } sts_type;

endpackage

`default_nettype wire

FILE: hw/rtl/spur_div.sv
// spur_div: restoring divider, one quotient bit per cycle.
// Used by spur_dp for the distance computation; depends on nothing else.
`default_nettype none

module spur_div #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    shifted;
   logic [DEN_W+1:0]  diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         step_in = STEP_W'(NUM_W);
      end else if (step_ff != '0) begin
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         done_in = (step_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/spur_dp.sv
// spur_dp: datapath of the ranger - configuration registers, tick and echo
// counters, distance multiplier and divider, response payload register.
// Depends on spur_pkg and spur_div.
`default_nettype none

module spur_dp #(
   parameter int COUNT_WIDTH = 24
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write,
   input  wire logic [spur_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [spur_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire spur_pkg::cmd_type                cmd,
   output spur_pkg::sts_type                     sts,
   output logic [spur_pkg::RSP_DATA_W-1:0]       rsp_data
);

   localparam int PROD_W = COUNT_WIDTH + spur_pkg::MM_W;

   logic [spur_pkg::TRIG_W-1:0] trig_ff, trig_in;
   logic [spur_pkg::TOUT_W-1:0] tout_ff, tout_in;
   logic [spur_pkg::TPM_W-1:0]  tpm_ff, tpm_in;
   logic [spur_pkg::MM_W-1:0]   mm_ff, mm_in;

   logic [spur_pkg::TICK_W-1:0] ticks_ff, ticks_in;
   logic [spur_pkg::TICK_W:0]   ticks_next;
   logic [COUNT_WIDTH-1:0]      high_ff, high_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic [spur_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic [spur_pkg::FLAG_W-1:0] flags_ff, flags_in;

   logic [spur_pkg::TPM_W-1:0]  divisor;
   logic [PROD_W-1:0]           quotient;
   logic                        div_done;
   logic [spur_pkg::DIST_W-1:0] dist_sat;

   // configuration writes
   always_comb begin
      trig_in = trig_ff;
      tout_in = tout_ff;
      tpm_in  = tpm_ff;
      mm_in   = mm_ff;
      if (csr_write) begin
         case (csr_index)
            spur_pkg::REG_TRIGGER_TICKS: trig_in = csr_data[spur_pkg::TRIG_W-1:0];
            spur_pkg::REG_TIMEOUT_TICKS: tout_in = csr_data[spur_pkg::TOUT_W-1:0];
            spur_pkg::REG_TICKS_PER_MS:  tpm_in  = csr_data[spur_pkg::TPM_W-1:0];
            spur_pkg::REG_MM_PER_MS:     mm_in   = csr_data[spur_pkg::MM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // counters
   always_comb begin
      ticks_next = {1'b0, ticks_ff} + (spur_pkg::TICK_W+1)'(1);
      ticks_in   = ticks_ff;
      if (cmd.cnt_clr) begin
         ticks_in = '0;
      end else if (cmd.cnt_inc) begin
         ticks_in = ticks_next[spur_pkg::TICK_W-1:0];
      end
      high_in = high_ff;
      if (cmd.high_set) begin
         high_in = COUNT_WIDTH'(1);
      end else if (cmd.high_inc && !(&high_ff)) begin
         high_in = high_ff + COUNT_WIDTH'(1);
      end
   end

   assign sts.trig_hit = ticks_next >= (spur_pkg::TICK_W+1)'(trig_ff);
   assign sts.tout_hit = ticks_next >= (spur_pkg::TICK_W+1)'(tout_ff);
   assign sts.div_done = div_done;

   // distance: product, divide, saturate
   assign prod_in = cmd.mul_go ? PROD_W'(mm_ff) * PROD_W'(high_ff) : prod_ff;
   assign divisor = (tpm_ff == '0) ? spur_pkg::TPM_W'(1) : tpm_ff;

   spur_div #(
      .NUM_W (PROD_W),
      .DEN_W (spur_pkg::TPM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (prod_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign dist_sat = (|quotient[PROD_W-1:spur_pkg::DIST_W]) ? '1
                                                             : quotient[spur_pkg::DIST_W-1:0];
   assign dist_in  = cmd.dist_load ? dist_sat : dist_ff;
   assign flags_in = cmd.rsp_load ? {cmd.rsp_tout, cmd.rsp_done, cmd.rsp_busy,
                                     cmd.rsp_lvl, cmd.rsp_en} : flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff  <= spur_pkg::TRIGGER_TICKS_RST;
         tout_ff  <= spur_pkg::TIMEOUT_TICKS_RST;
         tpm_ff   <= spur_pkg::TICKS_PER_MS_RST;
         mm_ff    <= spur_pkg::MM_PER_MS_RST;
         ticks_ff <= '0;
         high_ff  <= '0;
         dist_ff  <= '0;
      end else begin
         trig_ff  <= trig_in;
         tout_ff  <= tout_in;
         tpm_ff   <= tpm_in;
         mm_ff    <= mm_in;
         ticks_ff <= ticks_in;
         high_ff  <= high_in;
         dist_ff  <= dist_in;
      end
      prod_ff  <= prod_in;
      flags_ff <= flags_in;
   end

   // distance only changes on the edge that loads a response, so it is read live
   assign rsp_data = {(spur_pkg::RSP_DATA_W - spur_pkg::DIST_W - spur_pkg::FLAG_W)'(0),
                      dist_ff, flags_ff};

endmodule

`default_nettype wire

FILE: hw/rtl/spur_ctrl.sv
// spur_ctrl: measurement phase state machine and request/response sequencing.
// Drives the spur_dp datapath through spur_pkg::cmd_type; depends on spur_pkg.
`default_nettype none

module spur_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic          req_cmd,
   input  wire logic          req_echo,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire spur_pkg::sts_type sts,
   output spur_pkg::cmd_type  cmd
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_TRIG = 2'd1;
   localparam logic [1:0] PH_WAIT = 2'd2;
   localparam logic [1:0] PH_HIGH = 2'd3;

   localparam logic [1:0] SEQ_IN  = 2'd0;
   localparam logic [1:0] SEQ_MUL = 2'd1;
   localparam logic [1:0] SEQ_DIV = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [1:0] seq_ff, seq_in;
   logic       pin_ff, pin_in;
   logic       valid_ff, valid_in;
   logic       accept;
   logic [1:0] ph;
   logic       fin, fin_done;

   assign req_tready = (seq_ff == SEQ_IN) && (!valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      phase_in = phase_ff;
      seq_in   = seq_ff;
      pin_in   = pin_ff;
      ph       = phase_ff;
      fin      = 1'b0;
      fin_done = 1'b0;
      case (seq_ff)
         SEQ_IN: begin
            if (accept) begin
               if (phase_ff == PH_IDLE) begin
                  if (req_cmd) begin
                     ph     = PH_TRIG;
                     pin_in = 1'b1;
                  end else begin
                     cmd.rsp_en = pin_ff;
                  end
               end
               if (ph == PH_TRIG) begin
                  cmd.rsp_en  = 1'b1;
                  cmd.rsp_lvl = 1'b1;
                  if (sts.trig_hit) begin
                     ph          = PH_WAIT;
                     cmd.cnt_clr = 1'b1;
                     pin_in      = 1'b0;
                  end else begin
                     cmd.cnt_inc = 1'b1;
                  end
               end else if (ph == PH_WAIT || ph == PH_HIGH) begin
                  if (ph == PH_WAIT) begin
                     if (req_echo) begin
                        ph           = PH_HIGH;
                        cmd.high_set = 1'b1;
                     end
                  end else if (req_echo) begin
                     cmd.high_inc = 1'b1;
                  end else begin
                     fin_done = 1'b1;
                  end
                  if (!fin_done) begin
                     cmd.cnt_inc = 1'b1;
                     if (sts.tout_hit) begin
                        cmd.rsp_tout = 1'b1;
                        fin          = 1'b1;
                     end
                  end
                  if (fin || fin_done) begin
                     ph          = PH_IDLE;
                     cmd.cnt_clr = 1'b1;
                  end
               end
               phase_in     = ph;
               cmd.rsp_busy = (ph != PH_IDLE);
               if (fin_done) begin
                  // echo fell: response waits for the distance
                  cmd.mul_go = 1'b1;
                  seq_in     = SEQ_MUL;
               end else begin
                  cmd.rsp_load = 1'b1;
               end
            end
         end
         SEQ_MUL: begin
            cmd.div_go = 1'b1;
            seq_in     = SEQ_DIV;
         end
         SEQ_DIV: begin
            if (sts.div_done) begin
               cmd.dist_load = 1'b1;
               cmd.rsp_load  = 1'b1;
               cmd.rsp_done  = 1'b1;
               seq_in        = SEQ_IN;
            end
         end
         default: begin
            seq_in = SEQ_IN;
         end
      endcase
      valid_in = cmd.rsp_load || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         seq_ff   <= SEQ_IN;
         pin_ff   <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         seq_ff   <= seq_in;
         pin_ff   <= pin_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |-> !cmd.rsp_load)
      else $error("response register overwritten while stalled");

   a_mul_then_div: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_MUL) |=> (seq_ff == SEQ_DIV))
      else $error("divide did not follow multiply");

   a_div_result: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_DIV && sts.div_done) |-> (cmd.dist_load && cmd.rsp_load))
      else $error("quotient ready but distance not reported");

   a_idle_while_div: assert property (@(posedge clock) disable iff (reset)
      (seq_ff != SEQ_IN) |-> (phase_ff == PH_IDLE && !req_tready))
      else $error("phase active or request taken during distance computation");

endmodule

`default_nettype wire

FILE: hw/rtl/single_pin_ultrasonic_ranger.sv
// single_pin_ultrasonic_ranger: top level of the single-pin ultrasonic ranger.
// Depends on spur_pkg, spur_ctrl, spur_dp (and spur_div below it).
//
//  channel  dir  handshake            payload
//  req_     in   req_tvalid/tready    tuser: cmd; tdata[0]: echo_level
//  rsp_     out  rsp_tvalid/tready    tdata: drive enable, drive level, busy,
//                                     done, timed out, distance
//  csr_     in   csr_valid/ready      csr_index, csr_data
//
// One request is taken per clock while responses drain. The request on which
// the echo falls registers the multiply, then starts the divider for a
// bit-serial divide of COUNT_WIDTH + 10 quotient bits, and the response is
// loaded when the quotient is ready; no request is taken meanwhile.
// A stalled response holds; one response is buffered. Synchronous reset
// restores register defaults, idle phase with the pin driven low.
`default_nettype none

module single_pin_ultrasonic_ranger #(
   parameter int COUNT_WIDTH = 24
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [spur_pkg::REQ_DATA_W-1:0]  req_tdata,  // [0] echo_level, rest zero
   input  wire logic                             req_tuser,  // [0] cmd
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [spur_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // [0] pin_drive_enable,
                                                             // [1] pin_drive_level,
                                                             // [2] busy_res, [3] done_res,
                                                             // [4] timed_out,
                                                             // [20:5] distance
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [spur_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [spur_pkg::CSR_DATA_W-1:0]  csr_data
);

   spur_pkg::cmd_type cmd;
   spur_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   spur_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .req_echo   (req_tdata[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   spur_dp #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_tdata)
   );

endmodule

`default_nettype wire
